// ===== hw/rtl/rtmc_pkg.sv =====
// rtmc_pkg: shared types and constants of the range-to-MIDI controller
// used by rtmc_divider and range_to_midi_controller; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rtmc_pkg;

    // field widths
    localparam int RANGE_W = 13;
    localparam int STATUS_W = 4;
    localparam int LIMIT_W = 10;
    localparam int CHAN_W = 4;
    localparam int DATA7_W = 7;
    localparam int MODE_W = 2;
    localparam int CV_W = 14;
    localparam int QUOT_W = 17;
    localparam int STEP_W = 5;
    localparam int CFG_ADDR_W = 3;
    localparam int SLOT_N = 6;

    // sensor status meaning phase failure
    localparam logic [STATUS_W-1:0] PHASE_FAIL = 4'd4;

    // controller value and velocity ceilings
    localparam logic [CV_W-1:0] CV_MAX = 14'd16383;
    localparam logic [DATA7_W-1:0] VEL_MAX = 7'd127;

    // divider step counts
    localparam logic [STEP_W-1:0] CV_STEPS = 5'd14;
    localparam logic [STEP_W-1:0] VEL_STEPS = 5'd17;

    // message types
    localparam logic [1:0] MT_CTRL = 2'd0;
    localparam logic [1:0] MT_ON = 2'd1;
    localparam logic [1:0] MT_AT = 2'd2;
    localparam logic [1:0] MT_OFF = 2'd3;

    // trigger modes
    localparam logic [MODE_W-1:0] MODE_KEYBOARD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BUTTON = 2'd1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_LIMIT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_LIMIT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIDI_CHANNEL = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_NOTE_NUMBER = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CC_LOW = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CC_HIGH = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_MODE = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_ENABLE = 3'd7;

    // message slots in send order
    localparam int SLOT_PRE_OFF = 0;
    localparam int SLOT_CC_LOW = 1;
    localparam int SLOT_CC_HIGH = 2;
    localparam int SLOT_ON = 3;
    localparam int SLOT_AT = 4;
    localparam int SLOT_POST_OFF = 5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_CV_GO,
        ST_CV_WAIT,
        ST_VA_GO,
        ST_VA_WAIT,
        ST_VB_GO,
        ST_VB_WAIT,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    // divider request and response
    typedef struct packed {
        logic                start;
        logic [LIMIT_W-1:0]  divisor;
        logic [LIMIT_W-1:0]  rem_init;
        logic [QUOT_W-1:0]   dvd_init;
        logic [STEP_W-1:0]   steps;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic [QUOT_W-1:0]   quot;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rtmc_divider.sv =====
// rtmc_divider: radix-2 restoring divider, one quotient bit per cycle
// depends on rtmc_pkg for the request and response structs
`timescale 1ns / 1ps
`default_nettype none

module rtmc_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rtmc_pkg::div_req_t req,
    output rtmc_pkg::div_rsp_t      rsp
);

    logic                           busy_reg, busy_next;
    logic [rtmc_pkg::STEP_W-1:0]    cnt_reg, cnt_next;
    logic [rtmc_pkg::LIMIT_W-1:0]   rem_reg, rem_next;
    logic [rtmc_pkg::LIMIT_W-1:0]   div_reg, div_next;
    logic [rtmc_pkg::QUOT_W-1:0]    dvd_reg, dvd_next;
    logic [rtmc_pkg::LIMIT_W:0]     trial;
    logic [rtmc_pkg::LIMIT_W:0]     diff;
    logic                           ge;

    // one shift, compare and subtract step
    always_comb begin
        trial = {rem_reg, dvd_reg[rtmc_pkg::QUOT_W-1]};
        diff = trial - {1'b0, div_reg};
        ge = (trial >= {1'b0, div_reg});
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        dvd_next = dvd_reg;
        if (req.start) begin
            busy_next = (req.steps != '0);
            cnt_next = req.steps;
            rem_next = req.rem_init;
            div_next = req.divisor;
            dvd_next = req.dvd_init;
        end else if (busy_reg) begin
            rem_next = ge ? diff[rtmc_pkg::LIMIT_W-1:0] : trial[rtmc_pkg::LIMIT_W-1:0];
            dvd_next = {dvd_reg[rtmc_pkg::QUOT_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            busy_next = (cnt_reg != 5'd1);
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        dvd_reg <= dvd_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.quot = dvd_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/range_to_midi_controller.sv =====
// Range-to-MIDI controller: one range beat in, up to four MIDI message beats out; uses rtmc_pkg, rtmc_divider
// An accepted reading in an open window takes three passes of the shared radix-2 divider (two on its upper
// edge) of 14 + 17 + 17 steps before its first message beat; phase failures and closed or inverted
// windows skip the divider and go straight to the message decision.
// A new reading is accepted only in idle, once the previous one has queued its last message beat.
// Reset: synchronous active-low aresetn restores register defaults and clears state.
`timescale 1ns / 1ps
`default_nettype none

module range_to_midi_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [9:0]  cfg_wdata,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [12:0] range_mm
    input  wire logic [3:0]  s_tuser,   // [3:0] range_status
    // message stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [1:0] message_type, [5:2] channel_out,
                                        // [12:6] data_first, [19:13] data_second
    output logic             m_tlast    // last_message
);

    localparam int LW = rtmc_pkg::LIMIT_W;
    localparam int QW = rtmc_pkg::QUOT_W;
    localparam int DW = rtmc_pkg::DATA7_W;

    rtmc_pkg::state_t state_reg, state_next;

    // configuration registers
    logic [LW-1:0]                 lo_reg, hi_reg;
    logic [rtmc_pkg::CHAN_W-1:0]   chan_reg;
    logic [DW-1:0]                 note_reg, cc_lo_reg, cc_hi_reg;
    logic [rtmc_pkg::MODE_W-1:0]   mode_reg;
    logic                          oe_reg;

    // item state
    logic [rtmc_pkg::RANGE_W-1:0]  range_reg, range_next;
    logic                          valid_reg, valid_next;
    logic [LW-1:0]                 held_reg, held_next;
    logic                          meas_reg, meas_next;
    logic                          play_reg, play_next;
    logic                          tog_reg, tog_next;
    logic [rtmc_pkg::CV_W-1:0]     cv_reg, cv_next;
    logic [DW-1:0]                 vel_reg, vel_next;
    logic [QW-1:0]                 q1_reg, q1_next;
    logic [rtmc_pkg::SLOT_N-1:0]   mask_reg, mask_next;

    // output register
    logic                          mvalid_reg, mvalid_next;
    logic [1:0]                    mtype_reg, mtype_next;
    logic [rtmc_pkg::CHAN_W-1:0]   mchan_reg, mchan_next;
    logic [DW-1:0]                 mfirst_reg, mfirst_next;
    logic [DW-1:0]                 msecond_reg, msecond_next;
    logic                          mlast_reg, mlast_next;

    // helpers
    logic [rtmc_pkg::RANGE_W-1:0]  clamp_t;
    logic [LW-1:0]                 win_d;
    logic [LW-1:0]                 win_x;
    logic signed [QW+1:0]          vel_sum;
    logic                          is_kb, is_btn;
    logic [rtmc_pkg::SLOT_N-1:0]   mask_left;

    rtmc_pkg::div_req_t div_req;
    rtmc_pkg::div_rsp_t div_rsp;

    rtmc_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    // value times 127 as a shift and subtract
    function automatic logic [QW-1:0] times127(input logic [LW-1:0] v);
        times127 = ({7'd0, v} << 7) - {7'd0, v};
    endfunction

    assign s_tready = (state_reg == rtmc_pkg::ST_IDLE);
    assign is_kb = (mode_reg == rtmc_pkg::MODE_KEYBOARD);
    assign is_btn = (mode_reg == rtmc_pkg::MODE_BUTTON);
    assign win_d = hi_reg - lo_reg;
    assign win_x = held_reg - lo_reg;

    // sequencer: next state and datapath
    always_comb begin
        state_next = state_reg;
        range_next = range_reg;
        valid_next = valid_reg;
        held_next = held_reg;
        meas_next = meas_reg;
        play_next = play_reg;
        tog_next = tog_reg;
        cv_next = cv_reg;
        vel_next = vel_reg;
        q1_next = q1_reg;
        mask_next = mask_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mtype_next = mtype_reg;
        mchan_next = mchan_reg;
        mfirst_next = mfirst_reg;
        msecond_next = msecond_reg;
        mlast_next = mlast_reg;
        mask_left = mask_reg;
        clamp_t = range_reg;
        vel_sum = '0;
        div_req.start = 1'b0;
        div_req.divisor = win_d;
        div_req.rem_init = '0;
        div_req.dvd_init = '0;
        div_req.steps = rtmc_pkg::VEL_STEPS;

        unique case (state_reg)
            rtmc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    range_next = s_tdata[rtmc_pkg::RANGE_W-1:0];
                    valid_next = (s_tuser != rtmc_pkg::PHASE_FAIL);
                    state_next = rtmc_pkg::ST_CLAMP;
                end
            end
            // clamp a valid reading into the window and hold it
            rtmc_pkg::ST_CLAMP: begin
                if (clamp_t < {3'd0, lo_reg}) begin
                    clamp_t = {3'd0, lo_reg};
                end
                if (clamp_t > {3'd0, hi_reg}) begin
                    clamp_t = {3'd0, hi_reg};
                end
                if (valid_reg) begin
                    held_next = clamp_t[LW-1:0];
                end
                state_next = rtmc_pkg::ST_CV_GO;
            end
            // controller value: phase failure, special windows and full scale, or start the division
            rtmc_pkg::ST_CV_GO: begin
                if (!valid_reg) begin
                    cv_next = '0;
                    state_next = rtmc_pkg::ST_DECIDE;
                end else if (hi_reg == lo_reg) begin
                    cv_next = '0;
                    vel_next = '0;
                    state_next = rtmc_pkg::ST_DECIDE;
                end else if (hi_reg < lo_reg) begin
                    cv_next = rtmc_pkg::CV_MAX;
                    vel_next = rtmc_pkg::VEL_MAX;
                    state_next = rtmc_pkg::ST_DECIDE;
                end else if (win_x == win_d) begin
                    // full scale saturates
                    cv_next = rtmc_pkg::CV_MAX;
                    state_next = rtmc_pkg::ST_VA_GO;
                end else begin
                    div_req.start = 1'b1;
                    div_req.rem_init = win_x;
                    div_req.steps = rtmc_pkg::CV_STEPS;
                    state_next = rtmc_pkg::ST_CV_WAIT;
                end
            end
            rtmc_pkg::ST_CV_WAIT: begin
                if (!div_rsp.busy) begin
                    cv_next = div_rsp.quot[rtmc_pkg::CV_W-1:0];
                    state_next = rtmc_pkg::ST_VA_GO;
                end
            end
            // velocity: 127*held / d
            rtmc_pkg::ST_VA_GO: begin
                div_req.start = 1'b1;
                div_req.dvd_init = times127(held_reg);
                state_next = rtmc_pkg::ST_VA_WAIT;
            end
            rtmc_pkg::ST_VA_WAIT: begin
                if (!div_rsp.busy) begin
                    q1_next = div_rsp.quot;
                    state_next = rtmc_pkg::ST_VB_GO;
                end
            end
            // velocity: 127*high / d
            rtmc_pkg::ST_VB_GO: begin
                div_req.start = 1'b1;
                div_req.dvd_init = times127(hi_reg);
                state_next = rtmc_pkg::ST_VB_WAIT;
            end
            rtmc_pkg::ST_VB_WAIT: begin
                if (!div_rsp.busy) begin
                    vel_sum = $signed({2'b00, q1_reg}) - $signed({2'b00, div_rsp.quot})
                              + $signed({{(QW-DW+2){1'b0}}, rtmc_pkg::VEL_MAX});
                    if (vel_sum < 0) begin
                        vel_next = '0;
                    end else if (vel_sum > $signed({{(QW-DW+2){1'b0}}, rtmc_pkg::VEL_MAX})) begin
                        vel_next = rtmc_pkg::VEL_MAX;
                    end else begin
                        vel_next = vel_sum[DW-1:0];
                    end
                    state_next = rtmc_pkg::ST_DECIDE;
                end
            end
            // note logic: pick the messages and update the flags
            rtmc_pkg::ST_DECIDE: begin
                mask_left = '0;
                meas_next = valid_reg;
                if (!valid_reg && meas_reg) begin
                    tog_next = !tog_reg;
                    if (is_kb) begin
                        mask_left[rtmc_pkg::SLOT_PRE_OFF] = 1'b1;
                    end
                end
                if (oe_reg) begin
                    mask_left[rtmc_pkg::SLOT_CC_LOW] = 1'b1;
                    mask_left[rtmc_pkg::SLOT_CC_HIGH] = 1'b1;
                    if (is_kb) begin
                        if (!play_reg && valid_reg) begin
                            mask_left[rtmc_pkg::SLOT_ON] = 1'b1;
                            mask_left[rtmc_pkg::SLOT_AT] = 1'b1;
                            play_next = 1'b1;
                        end else if (play_reg && valid_reg) begin
                            mask_left[rtmc_pkg::SLOT_AT] = 1'b1;
                        end else if (play_reg && !valid_reg) begin
                            mask_left[rtmc_pkg::SLOT_POST_OFF] = 1'b1;
                            play_next = 1'b0;
                        end
                    end else if (is_btn && valid_reg) begin
                        if (!tog_reg && !play_reg) begin
                            mask_left[rtmc_pkg::SLOT_ON] = 1'b1;
                            play_next = 1'b1;
                        end else if (tog_reg && play_reg) begin
                            mask_left[rtmc_pkg::SLOT_POST_OFF] = 1'b1;
                            play_next = 1'b0;
                        end
                    end
                end
                mask_next = mask_left;
                state_next = (mask_left != '0) ? rtmc_pkg::ST_EMIT : rtmc_pkg::ST_IDLE;
            end
            // send queued messages in slot order into the output register
            rtmc_pkg::ST_EMIT: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mchan_next = chan_reg;
                    mfirst_next = note_reg;
                    msecond_next = '0;
                    priority if (mask_reg[rtmc_pkg::SLOT_PRE_OFF]) begin
                        mask_left[rtmc_pkg::SLOT_PRE_OFF] = 1'b0;
                        mtype_next = rtmc_pkg::MT_OFF;
                    end else if (mask_reg[rtmc_pkg::SLOT_CC_LOW]) begin
                        mask_left[rtmc_pkg::SLOT_CC_LOW] = 1'b0;
                        mtype_next = rtmc_pkg::MT_CTRL;
                        mfirst_next = cc_lo_reg;
                        msecond_next = cv_reg[DW-1:0];
                    end else if (mask_reg[rtmc_pkg::SLOT_CC_HIGH]) begin
                        mask_left[rtmc_pkg::SLOT_CC_HIGH] = 1'b0;
                        mtype_next = rtmc_pkg::MT_CTRL;
                        mfirst_next = cc_hi_reg;
                        msecond_next = cv_reg[rtmc_pkg::CV_W-1:DW];
                    end else if (mask_reg[rtmc_pkg::SLOT_ON]) begin
                        mask_left[rtmc_pkg::SLOT_ON] = 1'b0;
                        mtype_next = rtmc_pkg::MT_ON;
                        msecond_next = vel_reg;
                    end else if (mask_reg[rtmc_pkg::SLOT_AT]) begin
                        mask_left[rtmc_pkg::SLOT_AT] = 1'b0;
                        mtype_next = rtmc_pkg::MT_AT;
                        msecond_next = vel_reg;
                    end else begin
                        mask_left[rtmc_pkg::SLOT_POST_OFF] = 1'b0;
                        mtype_next = rtmc_pkg::MT_OFF;
                    end
                    mlast_next = (mask_left == '0);
                    mask_next = mask_left;
                    if (mask_left == '0) begin
                        state_next = rtmc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = rtmc_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rtmc_pkg::ST_IDLE;
            held_reg <= '0;
            meas_reg <= 1'b0;
            play_reg <= 1'b0;
            tog_reg <= 1'b0;
            mask_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            held_reg <= held_next;
            meas_reg <= meas_next;
            play_reg <= play_next;
            tog_reg <= tog_next;
            mask_reg <= mask_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        range_reg <= range_next;
        valid_reg <= valid_next;
        cv_reg <= cv_next;
        vel_reg <= vel_next;
        q1_reg <= q1_next;
        mtype_reg <= mtype_next;
        mchan_reg <= mchan_next;
        mfirst_reg <= mfirst_next;
        msecond_reg <= msecond_next;
        mlast_reg <= mlast_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg <= '0;
            hi_reg <= 10'd1023;
            chan_reg <= '0;
            note_reg <= 7'd60;
            cc_lo_reg <= 7'd32;
            cc_hi_reg <= '0;
            mode_reg <= rtmc_pkg::MODE_KEYBOARD;
            oe_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                rtmc_pkg::REG_LOW_LIMIT:     lo_reg <= cfg_wdata;
                rtmc_pkg::REG_HIGH_LIMIT:    hi_reg <= cfg_wdata;
                rtmc_pkg::REG_MIDI_CHANNEL:  chan_reg <= cfg_wdata[rtmc_pkg::CHAN_W-1:0];
                rtmc_pkg::REG_NOTE_NUMBER:   note_reg <= cfg_wdata[DW-1:0];
                rtmc_pkg::REG_CC_LOW:        cc_lo_reg <= cfg_wdata[DW-1:0];
                rtmc_pkg::REG_CC_HIGH:       cc_hi_reg <= cfg_wdata[DW-1:0];
                rtmc_pkg::REG_TRIGGER_MODE:  mode_reg <= cfg_wdata[rtmc_pkg::MODE_W-1:0];
                rtmc_pkg::REG_OUTPUT_ENABLE: oe_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // output ports
    assign m_tvalid = mvalid_reg;
    assign m_tdata = {4'd0, msecond_reg, mfirst_reg, mchan_reg, mtype_reg};
    assign m_tlast = mlast_reg;

`ifndef SYNTHESIS
    // no reading is taken while a division is in flight
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !div_rsp.busy)
        else $error("input beat accepted while divider busy");

    // divider is only restarted once idle
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    // emit state always has a queued message
    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rtmc_pkg::ST_EMIT) |-> (mask_reg != '0))
        else $error("emit state with empty message queue");

    // playing starts only together with a queued note on
    a_play_on: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(play_reg) |-> mask_reg[rtmc_pkg::SLOT_ON])
        else $error("playing flag set without note on");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: self-checking bench for range_to_midi_controller, directed table then random phases
// predicts each midi message beat from the range beat and compares on the message stream
// depends on rtmc_pkg and the range_to_midi_controller rtl
`timescale 1ns / 1ps

module testbench;

    // one midi message beat as seen on the output stream
    typedef struct {
        logic [1:0] kind;
        logic [3:0] chan;
        logic [6:0] first;
        logic [6:0] second;
        logic       last;
    } midi_msg_t;

    // one line of the directed script: either a register write or a range reading
    typedef struct {
        bit          is_write;
        logic [2:0]  addr;
        int          value;
        logic [3:0]  status;
        bit          typed;
        logic [13:0] cv_typed;
        logic [6:0]  vel_typed;
    } script_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [9:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;

    range_to_midi_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // register copies
    int win_lo, win_hi, chan, note, cc_lo, cc_hi, mode, out_en;
    // controller state copies
    int held_mm;
    bit measuring, playing, toggle;

    midi_msg_t   pending_msgs[$];
    script_row_t script[$];

    // messages of the reading being predicted
    logic [1:0] batch_kind[0:3];
    logic [6:0] batch_first[0:3];
    logic [6:0] batch_second[0:3];
    int         batch_n;

    int errors;
    bit no_gaps;
    bit sent_since_idle;

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic script_row_t write_row(logic [2:0] addr, int value);
        script_row_t r;
        r = '{1'b1, addr, value, 4'd0, 1'b0, 14'd0, 7'd0};
        return r;
    endfunction

    function automatic script_row_t read_row(int range_mm, logic [3:0] status, bit typed,
                                             logic [13:0] cv_typed, logic [6:0] vel_typed);
        script_row_t r;
        r = '{1'b0, 3'd0, range_mm, status, typed, cv_typed, vel_typed};
        return r;
    endfunction

    // velocity from the held range and the window, saturated to 0..127
    function automatic logic [6:0] velocity_now();
        int span;
        int v;
        span = win_hi - win_lo;
        if (span == 0) return 7'd0;
        if (span < 0) return rtmc_pkg::VEL_MAX;
        v = (127 * held_mm) / span + (127 - (127 * win_hi) / span);
        if (v < 0) v = 0;
        if (v > 127) v = 127;
        return v[6:0];
    endfunction

    function automatic void batch_add(logic [1:0] kind, int first, logic [6:0] second);
        batch_kind[batch_n] = kind;
        batch_first[batch_n] = first[6:0];
        batch_second[batch_n] = second;
        batch_n++;
    endfunction

    // expected messages of one accepted reading, state updated as the block does
    task automatic predict_messages(input int range_mm, input logic [3:0] status,
                                    input bit typed, input logic [13:0] cv_typed,
                                    input logic [6:0] vel_typed);
        int clamped;
        int cv;
        bit keyboard;
        bit button;
        midi_msg_t m;
        cv = 0;
        batch_n = 0;
        keyboard = (mode == int'(rtmc_pkg::MODE_KEYBOARD));
        button = (mode == int'(rtmc_pkg::MODE_BUTTON));
        if (status != rtmc_pkg::PHASE_FAIL) begin
            clamped = range_mm;
            if (clamped < win_lo) clamped = win_lo;
            if (clamped > win_hi) clamped = win_hi;
            held_mm = clamped & 1023;
            if (win_hi == win_lo) begin
                cv = 0;
            end else if (win_hi < win_lo) begin
                cv = int'(rtmc_pkg::CV_MAX);
            end else begin
                cv = (16384 * (held_mm - win_lo)) / (win_hi - win_lo);
                if (cv > int'(rtmc_pkg::CV_MAX)) cv = int'(rtmc_pkg::CV_MAX);
            end
            measuring = 1'b1;
        end else begin
            // phase failure after valid readings flips the button and may end the note
            if (measuring) begin
                toggle = !toggle;
                if (keyboard) batch_add(rtmc_pkg::MT_OFF, note, 7'd0);
            end
            measuring = 1'b0;
        end
        if (typed) cv = int'(cv_typed);

        if (out_en == 1) begin
            batch_add(rtmc_pkg::MT_CTRL, cc_lo, cv[6:0]);
            batch_add(rtmc_pkg::MT_CTRL, cc_hi, cv[13:7]);
            if (keyboard) begin
                if (!playing && measuring) begin
                    batch_add(rtmc_pkg::MT_ON, note, typed ? vel_typed : velocity_now());
                    playing = 1'b1;
                end
                if (playing && measuring)
                    batch_add(rtmc_pkg::MT_AT, note, typed ? vel_typed : velocity_now());
                if (playing && !measuring) begin
                    batch_add(rtmc_pkg::MT_OFF, note, 7'd0);
                    playing = 1'b0;
                end
            end else if (button && measuring) begin
                if (!toggle && !playing) begin
                    batch_add(rtmc_pkg::MT_ON, note, typed ? vel_typed : velocity_now());
                    playing = 1'b1;
                end else if (toggle && playing) begin
                    batch_add(rtmc_pkg::MT_OFF, note, 7'd0);
                    playing = 1'b0;
                end
            end
        end

        for (int i = 0; i < batch_n; i++) begin
            m.kind = batch_kind[i];
            m.chan = chan[3:0];
            m.first = batch_first[i];
            m.second = batch_second[i];
            m.last = (i == batch_n - 1);
            pending_msgs.push_back(m);
        end
    endtask

    // let the block drain and finish any reading that sends nothing
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_msgs.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        sent_since_idle = 1'b0;
    endtask

    // one register write, shadow copy updated alongside
    task automatic write_reg(input logic [2:0] addr, input int value);
        if (sent_since_idle) settle();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value[9:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            rtmc_pkg::REG_LOW_LIMIT:     win_lo = value & 1023;
            rtmc_pkg::REG_HIGH_LIMIT:    win_hi = value & 1023;
            rtmc_pkg::REG_MIDI_CHANNEL:  chan = value & 15;
            rtmc_pkg::REG_NOTE_NUMBER:   note = value & 127;
            rtmc_pkg::REG_CC_LOW:        cc_lo = value & 127;
            rtmc_pkg::REG_CC_HIGH:       cc_hi = value & 127;
            rtmc_pkg::REG_TRIGGER_MODE:  mode = value & 3;
            rtmc_pkg::REG_OUTPUT_ENABLE: out_en = value & 1;
            default: ;
        endcase
    endtask

    // offer one range beat after a random gap, predict once accepted
    task automatic send_reading(input int range_mm, input logic [3:0] status, input bit typed,
                                input logic [13:0] cv_typed, input logic [6:0] vel_typed);
        if (!no_gaps) begin
            while ($urandom_range(0, 99) < 18) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, range_mm[12:0]};
        s_tuser <= status;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_messages(range_mm, status, typed, cv_typed, vel_typed);
        sent_since_idle = 1'b1;
    endtask

    function automatic int pick_limit();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1023;
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    // message side: check each beat, random back-pressure, a stretch without back-pressure and one long hold-off
    int  beats_seen;
    int  hold_left;
    bit  hold_done;

    always @(posedge aclk) begin : message_side
        midi_msg_t want;
        if (m_tvalid && m_tready) begin
            beats_seen++;
            if (pending_msgs.size() == 0) begin
                $error("unexpected message beat: tdata %h tlast %b", m_tdata, m_tlast);
                errors++;
            end else begin
                want = pending_msgs.pop_front();
                if (m_tdata[1:0] !== want.kind) begin
                    $error("message_type: expected %0d, got %0d", want.kind, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[5:2] !== want.chan) begin
                    $error("channel_out: expected %0d, got %0d", want.chan, m_tdata[5:2]);
                    errors++;
                end
                if (m_tdata[12:6] !== want.first) begin
                    $error("data_first: expected %0d, got %0d", want.first, m_tdata[12:6]);
                    errors++;
                end
                if (m_tdata[19:13] !== want.second) begin
                    $error("data_second: expected %0d, got %0d", want.second, m_tdata[19:13]);
                    errors++;
                end
                if (m_tdata[23:20] !== 4'd0) begin
                    $error("tdata padding: expected 0, got %0d", m_tdata[23:20]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_message: expected %0d, got %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
        if (beats_seen == 80 && !hold_done) begin
            hold_left = 600;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (beats_seen >= 300 && beats_seen < 450) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 18);
        end
    end

    initial begin : stimulus
        int lo;
        int hi;
        int swap;
        int range_mm;
        logic [3:0] status;
        script_row_t row;

        errors = 0;
        beats_seen = 0;
        hold_left = 0;
        hold_done = 1'b0;
        no_gaps = 1'b0;
        sent_since_idle = 1'b0;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr <= 3'd0;
        cfg_wdata <= 10'd0;
        s_tvalid <= 1'b0;
        s_tdata <= 16'd0;
        s_tuser <= 4'd0;
        m_tready <= 1'b0;

        // register defaults and cleared state
        win_lo = 0; win_hi = 1023; chan = 0; note = 60;
        cc_lo = 32; cc_hi = 0; mode = 0; out_en = 0;
        held_mm = 0; measuring = 1'b0; playing = 1'b0; toggle = 1'b0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // output disabled after reset: only the keyboard note off on a phase failure
        script.push_back(read_row(500, 4'd0, 1'b0, 14'd0, 7'd0));
        script.push_back(read_row(0, rtmc_pkg::PHASE_FAIL, 1'b0, 14'd0, 7'd0));
        script.push_back(write_row(rtmc_pkg::REG_OUTPUT_ENABLE, 1));
        // window extremes, with saturation at the top
        script.push_back(read_row(0, 4'd0, 1'b1, 14'd0, 7'd0));
        script.push_back(read_row(8191, 4'd15, 1'b1, rtmc_pkg::CV_MAX, rtmc_pkg::VEL_MAX));
        script.push_back(read_row(1023, 4'd0, 1'b1, rtmc_pkg::CV_MAX, rtmc_pkg::VEL_MAX));
        // phase failure while playing, then again while not measuring
        script.push_back(read_row(0, rtmc_pkg::PHASE_FAIL, 1'b1, 14'd0, 7'd0));
        script.push_back(read_row(0, rtmc_pkg::PHASE_FAIL, 1'b1, 14'd0, 7'd0));
        // zero-width window
        script.push_back(write_row(rtmc_pkg::REG_LOW_LIMIT, 300));
        script.push_back(write_row(rtmc_pkg::REG_HIGH_LIMIT, 300));
        script.push_back(read_row(700, 4'd1, 1'b1, 14'd0, 7'd0));
        // inverted window
        script.push_back(write_row(rtmc_pkg::REG_LOW_LIMIT, 800));
        script.push_back(read_row(100, 4'd2, 1'b1, rtmc_pkg::CV_MAX, rtmc_pkg::VEL_MAX));
        // narrow window, clamp from below to a zero velocity
        script.push_back(write_row(rtmc_pkg::REG_LOW_LIMIT, 100));
        script.push_back(write_row(rtmc_pkg::REG_HIGH_LIMIT, 900));
        script.push_back(read_row(50, 4'd0, 1'b0, 14'd0, 7'd0));
        script.push_back(read_row(500, 4'd0, 1'b0, 14'd0, 7'd0));
        // button mode toggling
        script.push_back(write_row(rtmc_pkg::REG_TRIGGER_MODE, 1));
        script.push_back(read_row(0, rtmc_pkg::PHASE_FAIL, 1'b0, 14'd0, 7'd0));
        script.push_back(read_row(400, 4'd0, 1'b0, 14'd0, 7'd0));
        script.push_back(read_row(0, rtmc_pkg::PHASE_FAIL, 1'b0, 14'd0, 7'd0));
        script.push_back(read_row(400, 4'd0, 1'b0, 14'd0, 7'd0));
        script.push_back(read_row(600, 4'd3, 1'b0, 14'd0, 7'd0));
        // no notes, then the unused mode that behaves the same
        script.push_back(write_row(rtmc_pkg::REG_TRIGGER_MODE, 2));
        script.push_back(read_row(300, 4'd0, 1'b0, 14'd0, 7'd0));
        script.push_back(read_row(0, rtmc_pkg::PHASE_FAIL, 1'b0, 14'd0, 7'd0));
        script.push_back(write_row(rtmc_pkg::REG_TRIGGER_MODE, 3));
        script.push_back(read_row(8191, 4'd0, 1'b0, 14'd0, 7'd0));
        script.push_back(read_row(0, rtmc_pkg::PHASE_FAIL, 1'b0, 14'd0, 7'd0));
        // channel and numbers at their top, keyboard again
        script.push_back(write_row(rtmc_pkg::REG_MIDI_CHANNEL, 15));
        script.push_back(write_row(rtmc_pkg::REG_NOTE_NUMBER, 127));
        script.push_back(write_row(rtmc_pkg::REG_CC_LOW, 127));
        script.push_back(write_row(rtmc_pkg::REG_CC_HIGH, 127));
        script.push_back(write_row(rtmc_pkg::REG_TRIGGER_MODE, 0));
        script.push_back(read_row(4096, 4'd8, 1'b0, 14'd0, 7'd0));
        script.push_back(read_row(0, rtmc_pkg::PHASE_FAIL, 1'b0, 14'd0, 7'd0));
        // and at zero
        script.push_back(write_row(rtmc_pkg::REG_MIDI_CHANNEL, 0));
        script.push_back(write_row(rtmc_pkg::REG_NOTE_NUMBER, 0));
        script.push_back(write_row(rtmc_pkg::REG_CC_LOW, 0));
        script.push_back(write_row(rtmc_pkg::REG_CC_HIGH, 0));
        script.push_back(read_row(900, 4'd0, 1'b0, 14'd0, 7'd0));
        script.push_back(read_row(0, rtmc_pkg::PHASE_FAIL, 1'b0, 14'd0, 7'd0));

        foreach (script[i]) begin
            row = script[i];
            if (row.is_write)
                write_reg(row.addr, row.value);
            else
                send_reading(row.value, row.status, row.typed, row.cv_typed, row.vel_typed);
        end

        // random phases, each with fresh settings
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin lo = 0; hi = 1023; end
                1: begin lo = 0; hi = 1; end
                2: begin lo = 1022; hi = 1023; end
                default: begin
                    lo = pick_limit();
                    hi = pick_limit();
                    if (lo > hi && $urandom_range(0, 99) < 85) begin
                        swap = lo; lo = hi; hi = swap;
                    end
                    if ($urandom_range(0, 19) == 0) hi = lo;
                end
            endcase
            write_reg(rtmc_pkg::REG_LOW_LIMIT, lo);
            write_reg(rtmc_pkg::REG_HIGH_LIMIT, hi);
            write_reg(rtmc_pkg::REG_MIDI_CHANNEL, $urandom_range(0, 15));
            write_reg(rtmc_pkg::REG_NOTE_NUMBER, $urandom_range(0, 127));
            write_reg(rtmc_pkg::REG_CC_LOW, $urandom_range(0, 127));
            write_reg(rtmc_pkg::REG_CC_HIGH, $urandom_range(0, 127));
            write_reg(rtmc_pkg::REG_TRIGGER_MODE, (ph < 3) ? ph % 2 : $urandom_range(0, 3));
            // early phases always send, so the long hold-off lands while readings flow
            write_reg(rtmc_pkg::REG_OUTPUT_ENABLE,
                      int'((ph < 3) || ($urandom_range(0, 9) != 0)));
            no_gaps = (ph == 4 || ph == 5);

            // runs of valid readings broken by phase failures
            for (int k = 0; k < 25; k++) begin
                if ($urandom_range(0, 99) < 22) begin
                    status = rtmc_pkg::PHASE_FAIL;
                end else if ($urandom_range(0, 3) == 0) begin
                    status = 4'($urandom_range(0, 15));
                    if (status == rtmc_pkg::PHASE_FAIL) status = 4'd12;
                end else begin
                    status = 4'd0;
                end
                if ($urandom_range(0, 4) == 0)
                    range_mm = $urandom_range(0, 8191);
                else
                    range_mm = $urandom_range(0, 1100);
                send_reading(range_mm, status, 1'b0, 14'd0, 7'd0);
            end
        end
        no_gaps = 1'b0;

        settle();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
